// File: rtl/ftach_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer package
// Shared widths, register map, reset values and the types that pass between
// the measurement front end, the queue and the speed computation back end.
// ----------------------------------------------------------------------------
package ftach_pkg;

  localparam int CAP_W  = 16;   // capture timer width
  localparam int CLK_W  = 27;   // timer_clock_hz register width
  localparam int SUM_W  = 18;   // sum of three 16-bit intervals
  localparam int CNT_W  = 2;    // number of qualifying intervals
  localparam int RPM_W  = 16;
  localparam int NUM_W  = 33;   // 60 * (2^27 - 1) fits in 33 bits
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int EDGES_PER_REV      = 4;
  localparam int QUEUE_DEPTH        = 2;
  localparam int SECONDS_PER_MINUTE = 60;

  localparam logic [CAP_W-1:0] PERIOD_RESET = 16'hFFFF;
  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 27'd1000000;
  localparam logic [CAP_W-1:0] MIN_IV_RESET = 16'd500;
  localparam logic [RPM_W-1:0] RPM_MAX      = 16'hFFFF;

  // Register indexes; the byte address is four times the index.
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_CLK_HZ = 2'd1;
  localparam logic [1:0] REG_MIN_IV = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0] timer_period;
    logic [CLK_W-1:0] timer_clock_hz;
    logic [CAP_W-1:0] min_interval;
  } cfg_t;

  // One classified measurement waiting for the back end.
  typedef struct packed {
    logic             channel;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } meas_t;

  // Divider command: start pulse and number of quotient bits to produce.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/ftach_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer front end
// Forms the three capture intervals with wrap repair, keeps those above the
// minimum, and reduces them to a wide sum and a count.
// ----------------------------------------------------------------------------
module ftach_front (
  input  ftach_pkg::cfg_t                   cfg_i,
  input  logic                              channel_i,
  input  logic [ftach_pkg::CAP_W-1:0]       capture_a_i,
  input  logic [ftach_pkg::CAP_W-1:0]       capture_b_i,
  input  logic [ftach_pkg::CAP_W-1:0]       capture_c_i,
  input  logic [ftach_pkg::CAP_W-1:0]       capture_d_i,
  output ftach_pkg::meas_t                  meas_o
);
  import ftach_pkg::*;

  logic [CAP_W-1:0] cap  [4];
  logic [CAP_W-1:0] span [3];
  logic [2:0]       qual;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;

  assign cap[0] = capture_a_i;
  assign cap[1] = capture_b_i;
  assign cap[2] = capture_c_i;
  assign cap[3] = capture_d_i;

  always_comb begin
    logic [CAP_W:0] wrapped;
    wrapped = '0;
    sum     = '0;
    count   = '0;
    for (int k = 0; k < 3; k++) begin
      // A lower capture means the timer rolled over at the period.
      wrapped = {1'b0, cap[k+1]} + {1'b0, cfg_i.timer_period} - {1'b0, cap[k]};
      if (cap[k+1] >= cap[k]) begin
        span[k] = cap[k+1] - cap[k];
      end else begin
        span[k] = wrapped[CAP_W-1:0];
      end
      qual[k] = span[k] > cfg_i.min_interval;
      if (qual[k]) begin
        sum   = sum + SUM_W'(span[k]);
        count = count + CNT_W'(1);
      end
    end
  end

  assign meas_o.channel = channel_i;
  assign meas_o.sum     = sum;
  assign meas_o.count   = count;

endmodule
`default_nettype wire

// File: rtl/ftach_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer measurement queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ftach_fifo #(
  parameter int Depth = ftach_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ftach_pkg::meas_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ftach_pkg::meas_t rdata_o
);
  import ftach_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LvlW = $clog2(Depth + 1);

  meas_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            do_push, do_pop;

  assign full_o  = level_q == LvlW'(Depth);
  assign empty_o = level_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ftach_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer divider
// Restoring divider producing one quotient bit per cycle. The dividend is
// loaded left aligned so that only the requested number of bits is worked.
// ----------------------------------------------------------------------------
module ftach_div #(
  parameter int DenW = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ftach_pkg::div_ctrl_t          ctrl_i,
  input  logic [ftach_pkg::NUM_W-1:0]   dividend_i,
  input  logic [DenW-1:0]               divisor_i,
  output logic                          done_o,
  output logic [ftach_pkg::NUM_W-1:0]   quotient_o
);
  import ftach_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  dvd_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DenW-1:0]   dvs_q;
  logic [DenW-1:0]   rem_q;

  logic [DenW:0]     trial;
  logic              fits;
  logic [DenW:0]     diff;

  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit is worked.
      done_q <= busy_q && !ctrl_i.start && (cnt_q == STEP_W'(1));
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: rtl/ftach_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer back end
// Sequences the shared divider for the average interval and the speed, then
// saturates the speed and hands the result to the output register.
// ----------------------------------------------------------------------------
module ftach_back #(
  parameter int EdgesPerRev = ftach_pkg::EDGES_PER_REV
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ftach_pkg::CLK_W-1:0]   timer_clock_hz_i,
  input  logic                          empty_i,
  input  ftach_pkg::meas_t              meas_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          channel_out_o,
  output logic [ftach_pkg::RPM_W-1:0]   rpm_o,
  output logic [ftach_pkg::CNT_W-1:0]   valid_count_o,
  output logic                          saturated_o
);
  import ftach_pkg::*;

  localparam int DenW = $clog2(EdgesPerRev * 65536);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_AVG  = 4'b0010,
    ST_RPM  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  div_ctrl_t         div_ctrl;
  logic [NUM_W-1:0]  div_dividend;
  logic [DenW-1:0]   div_divisor;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  logic              chan_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RPM_W-1:0]  res_rpm_q, res_rpm_d;
  logic              res_sat_q, res_sat_d;
  logic              res_load;

  logic              out_valid_q;
  logic              out_free;
  logic              out_load;
  logic              quo_over;

  assign out_free = !out_valid_q || !out_stall_i;
  assign quo_over = |div_quo[NUM_W-1:RPM_W];

  always_comb begin
    state_d        = state_q;
    pop_o          = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.steps = STEP_W'(SUM_W);
    div_dividend   = {meas_i.sum, {(NUM_W - SUM_W){1'b0}}};
    div_divisor    = DenW'(meas_i.count);
    res_load       = 1'b0;
    res_rpm_d      = '0;
    res_sat_d      = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (meas_i.count == '0) begin
            res_load = 1'b1;
            state_d  = ST_HOLD;
          end else begin
            div_ctrl.start = 1'b1;
            state_d        = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        // Average interval is at most 65535, so the low bits carry it.
        div_dividend   = NUM_W'(timer_clock_hz_i) * NUM_W'(SECONDS_PER_MINUTE);
        div_divisor    = DenW'(div_quo[CAP_W-1:0]) * DenW'(EdgesPerRev);
        div_ctrl.steps = STEP_W'(NUM_W);
        if (div_done) begin
          div_ctrl.start = 1'b1;
          state_d        = ST_RPM;
        end
      end
      ST_RPM: begin
        if (div_done) begin
          res_load  = 1'b1;
          res_sat_d = quo_over;
          res_rpm_d = quo_over ? RPM_MAX : div_quo[RPM_W-1:0];
          state_d   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ftach_div #(
    .DenW (DenW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chan_q <= meas_i.channel;
      cnt_q  <= meas_i.count;
    end
    if (res_load) begin
      res_rpm_q <= res_rpm_d;
      res_sat_q <= res_sat_d;
    end
    if (out_load) begin
      channel_out_o <= chan_q;
      valid_count_o <= cnt_q;
      rpm_o         <= res_rpm_q;
      saturated_o   <= res_sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/fan_tachometer_rpm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fan tachometer, capture values to revolutions per minute
// Throughput: the back end takes one transaction at a time, since the shared
//   one-bit-a-cycle divider works its average and then its speed; the queue
//   accepts new transactions meanwhile.
// Reset: asynchronous active low; the queue and the output empty, and the
//   registers take period 65535, clock 1 MHz, minimum interval 500.
// ----------------------------------------------------------------------------
//
// Structure
//   ftach_front  forms three intervals from the four captures. A capture below
//                its predecessor means the timer wrapped at timer_period. Only
//                intervals strictly above min_interval are summed (18 bits, so
//                no overflow) and counted.
//   ftach_fifo   a two-entry queue. The input is stalled only when it is full,
//                so new transactions are taken while the back end is busy.
//   ftach_back   divides the sum by the count, then divides 60 * clock by
//                EdgesPerRev * average, both on one shared divider, and
//                saturates the speed at 65535. A result waits in a holding
//                state until the output register is free, which leaves the
//                queue free to fill in the meantime.
//
// A transaction without any qualifying interval skips the divider and gives
// rpm 0, count 0 and no saturation.
//
// Configuration is an APB-style slave with no wait states. The register index
// is paddr[3:2]; writes to the unused index are ignored and read back zero.
module fan_tachometer_rpm #(
  parameter int EdgesPerRev = ftach_pkg::EDGES_PER_REV,
  parameter int QueueDepth  = ftach_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             channel_i,
  input  logic [ftach_pkg::CAP_W-1:0]      capture_a_i,
  input  logic [ftach_pkg::CAP_W-1:0]      capture_b_i,
  input  logic [ftach_pkg::CAP_W-1:0]      capture_c_i,
  input  logic [ftach_pkg::CAP_W-1:0]      capture_d_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             channel_out_o,
  output logic [ftach_pkg::RPM_W-1:0]      rpm_o,
  output logic [ftach_pkg::CNT_W-1:0]      valid_count_o,
  output logic                             saturated_o,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ftach_pkg::ADDR_W-1:0]     paddr,
  input  logic [ftach_pkg::DATA_W-1:0]     pwdata,
  output logic [ftach_pkg::DATA_W-1:0]     prdata,
  output logic                             pready
);
  import ftach_pkg::*;

  cfg_t        cfg_q;
  logic        cfg_write;
  logic [1:0]  reg_idx;

  meas_t       front_meas;
  meas_t       queue_meas;
  logic        queue_full;
  logic        queue_empty;
  logic        queue_pop;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_period   <= PERIOD_RESET;
      cfg_q.timer_clock_hz <= CLK_HZ_RESET;
      cfg_q.min_interval   <= MIN_IV_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PERIOD: cfg_q.timer_period   <= pwdata[CAP_W-1:0];
        REG_CLK_HZ: cfg_q.timer_clock_hz <= pwdata[CLK_W-1:0];
        REG_MIN_IV: cfg_q.min_interval   <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = DATA_W'(cfg_q.timer_period);
      REG_CLK_HZ: prdata = DATA_W'(cfg_q.timer_clock_hz);
      REG_MIN_IV: prdata = DATA_W'(cfg_q.min_interval);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: classify the captures of each transaction as it arrives.
  // --------------------------------------------------------------------------
  ftach_front u_front (
    .cfg_i       (cfg_q),
    .channel_i   (channel_i),
    .capture_a_i (capture_a_i),
    .capture_b_i (capture_b_i),
    .capture_c_i (capture_c_i),
    .capture_d_i (capture_d_i),
    .meas_o      (front_meas)
  );

  // --------------------------------------------------------------------------
  // Queue between the two halves; its full flag is the input stall.
  // --------------------------------------------------------------------------
  assign in_stall_o = queue_full;

  ftach_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (front_meas),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .rdata_o (queue_meas)
  );

  // --------------------------------------------------------------------------
  // Back end: average, speed, saturation and the output register.
  // --------------------------------------------------------------------------
  ftach_back #(
    .EdgesPerRev (EdgesPerRev)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .timer_clock_hz_i (cfg_q.timer_clock_hz),
    .empty_i          (queue_empty),
    .meas_i           (queue_meas),
    .pop_o            (queue_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_out_o    (channel_out_o),
    .rpm_o            (rpm_o),
    .valid_count_o    (valid_count_o),
    .saturated_o      (saturated_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result without qualifying intervals carries a zero speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_count_o == '0 |-> rpm_o == '0 && !saturated_o)
    else $error("nonzero speed reported with no qualifying interval");

  // A saturated result always reads full scale and has a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> rpm_o == RPM_MAX && valid_count_o != '0)
    else $error("saturated result is not at full scale");

  // A period write lands in the register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write && reg_idx == REG_PERIOD |=> cfg_q.timer_period == $past(pwdata[CAP_W-1:0]))
    else $error("timer period register write lost");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> !queue_empty)
    else $error("queue popped while empty");

endmodule
`default_nettype wire
